[sv/c8_pkg.sv]
// ---------------------------------------------------------------------------
// CHIP-8 core package
// Shared payload types, status codes and controller/datapath interface.
// ---------------------------------------------------------------------------
package c8_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = 12;
  localparam logic [11:0] PC_RESET = 12'h200;

  typedef struct packed {
    logic        cmd;
    logic [11:0] load_addr;
    logic [7:0]  load_byte;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
  } item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic [1:0]  status;
    logic [15:0] index_value;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
  } result_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNKNOWN     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_STACK_FAULT = 2'd3
  } status_t;

  // memory address source
  typedef enum logic [1:0] {
    MA_LOAD = 2'd0,
    MA_PC   = 2'd1,
    MA_PC1  = 2'd2,
    MA_IDX  = 2'd3
  } maddr_sel_t;

  // memory write data source
  typedef enum logic [1:0] {
    MD_LOAD = 2'd0,
    MD_REG  = 2'd1,
    MD_BCD  = 2'd2
  } mdata_sel_t;

  typedef struct packed {
    logic       latch_item;
    maddr_sel_t maddr_sel;
    mdata_sel_t mdata_sel;
    logic       mem_we;
    logic       mem_re;
    logic       op_hi_we;
    logic       op_lo_we;
    logic       exec;      // run simple opcode
    logic       bcd_init;
    logic       bcd_step;
    logic [3:0] cnt;       // register / byte counter
    logic       reg_ld;    // V[cnt] <= mem data
    logic       idx_bump;  // I += X+1, pc += 2
    logic       finish;    // pc += 2 for BCD
    logic       emit;
  } ctrl_t;

  typedef enum logic [2:0] {
    K_SIMPLE = 3'd0,
    K_BCD    = 3'd1,
    K_STORE  = 3'd2,
    K_LOAD   = 3'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] x;
  } stat_t;

endpackage

[sv/chip8_instruction_core.sv]
// ---------------------------------------------------------------------------
// CHIP-8 instruction core
// Loads program bytes or executes one instruction per command.
// ---------------------------------------------------------------------------
// channel  | handshake          | payload
// command  | start / busy       | item   (c8_pkg::item_t)
// result   | result_valid pulse | result (c8_pkg::result_t)
//
// Each command steps through the controller states; FX33 runs twelve BCD
// steps plus three writes, and FX55/FX65 move X+1 bytes one at a time over
// the single memory port.
// Reset clears registers and stack; memory is undefined until written.
// Results are never stalled; busy is low during the strobe cycle, so the
// next transfer can share the edge that takes the result.
// ---------------------------------------------------------------------------
module chip8_instruction_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  c8_pkg::item_t   item,
  output logic            busy,
  output logic            result_valid,
  output c8_pkg::result_t result
);

  c8_pkg::ctrl_t ctrl;
  c8_pkg::stat_t stat;

  c8_control u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (item.cmd),
    .stat (stat),
    .busy (busy),
    .ctrl (ctrl)
  );

  c8_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .ctrl  (ctrl),
    .stat  (stat),
    .result(result),
    .done  (result_valid)
  );

endmodule

[sv/c8_datapath.sv]
// ---------------------------------------------------------------------------
// CHIP-8 datapath
// Memory, V registers, stack, I, timers, opcode execution and result outputs.
// ---------------------------------------------------------------------------
module c8_datapath (
  input  logic             clk,
  input  logic             rst,
  input  c8_pkg::item_t    item,
  input  c8_pkg::ctrl_t    ctrl,
  output c8_pkg::stat_t    stat,
  output c8_pkg::result_t  result,
  output logic             done
);

  logic [7:0]  mem [0:c8_pkg::MEM_BYTES-1];
  logic [7:0]  mem_q;
  logic [11:0] maddr;
  logic [7:0]  mdata;

  logic [7:0]  vreg [0:15];
  logic [11:0] stk  [0:c8_pkg::STACK_DEPTH-1];
  logic [4:0]  sp;
  logic [11:0] pc;
  logic [15:0] idx;
  logic [7:0]  dly, snd;
  logic [15:0] op;
  logic [1:0]  st;
  c8_pkg::item_t itm;

  logic [7:0] bcd_val;
  logic [3:0] bcd_h, bcd_t;

  always_comb begin
    unique case (ctrl.maddr_sel)
      c8_pkg::MA_LOAD: maddr = itm.load_addr;
      c8_pkg::MA_PC:   maddr = pc;
      c8_pkg::MA_PC1:  maddr = pc + 12'd1;
      c8_pkg::MA_IDX:  maddr = idx[11:0] + {8'd0, ctrl.cnt};
      default:         maddr = pc;
    endcase
    unique case (ctrl.mdata_sel)
      c8_pkg::MD_LOAD: mdata = itm.load_byte;
      c8_pkg::MD_REG:  mdata = vreg[ctrl.cnt];
      c8_pkg::MD_BCD: begin
        priority case (ctrl.cnt)
          4'd0:    mdata = {4'd0, bcd_h};
          4'd1:    mdata = {4'd0, bcd_t};
          default: mdata = bcd_val;
        endcase
      end
      default: mdata = itm.load_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_we) mem[maddr] <= mdata;
    if (ctrl.mem_re) mem_q <= mem[maddr];
  end

  // opcode fields
  logic [3:0]  ox, oy, on;
  logic [7:0]  onn, vx, vy;
  logic [11:0] onnn, nxt, skp;
  assign ox = op[11:8];
  assign oy = op[7:4];
  assign on = op[3:0];
  assign onn = op[7:0];
  assign onnn = op[11:0];
  assign vx = vreg[ox];
  assign vy = vreg[oy];
  assign nxt = pc + 12'd2;
  assign skp = pc + 12'd4;

  always_comb begin
    stat.x = op[11:8];
    stat.kind = c8_pkg::K_SIMPLE;
    if (op[15:12] == 4'hF) begin
      priority case (onn)
        8'h33:   stat.kind = c8_pkg::K_BCD;
        8'h55:   stat.kind = c8_pkg::K_STORE;
        8'h65:   stat.kind = c8_pkg::K_LOAD;
        default: stat.kind = c8_pkg::K_SIMPLE;
      endcase
    end
  end

  logic [8:0]  sum9;
  logic [16:0] isum;
  logic        key;
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign isum = {1'b0, idx} + {9'd0, vx};
  assign key  = itm.key_mask[vx[3:0]];

  // 8XYn result and flag for the arithmetic and shift forms
  logic [7:0] alu_r;
  logic       alu_f;
  always_comb begin
    alu_r = vx;
    alu_f = 1'b0;
    unique case (on)
      4'h4:    begin alu_r = sum9[7:0];       alu_f = sum9[8];   end
      4'h5:    begin alu_r = vx - vy;         alu_f = (vx >= vy); end
      4'h6:    begin alu_r = {1'b0, vx[7:1]}; alu_f = vx[0];     end
      4'h7:    begin alu_r = vy - vx;         alu_f = (vy >= vx); end
      4'hE:    begin alu_r = {vx[6:0], 1'b0}; alu_f = vx[7];     end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
      for (int i = 0; i < c8_pkg::STACK_DEPTH; i++) stk[i] <= 12'd0;
      sp <= 5'd0;
      pc <= c8_pkg::PC_RESET;
      idx <= 16'd0;
      dly <= 8'd0;
      snd <= 8'd0;
      op <= 16'd0;
      st <= c8_pkg::ST_OK;
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
      if (ctrl.latch_item) begin
        itm <= item;
        op <= 16'd0;
        st <= c8_pkg::ST_OK;
      end
      if (ctrl.op_hi_we) op[15:8] <= mem_q;
      if (ctrl.op_lo_we) op[7:0] <= mem_q;
      if (ctrl.reg_ld) vreg[ctrl.cnt] <= mem_q;
      if (ctrl.idx_bump) begin
        idx <= idx + {12'd0, ox} + 16'd1;
        pc <= nxt;
      end
      if (ctrl.finish) pc <= nxt;
      if (ctrl.exec) begin
        unique case (op[15:12])
          4'h0: begin
            if (op == 16'h00E0) st <= c8_pkg::ST_UNSUPPORTED;
            else if (op == 16'h00EE) begin
              if (sp == 5'd0) st <= c8_pkg::ST_STACK_FAULT;
              else begin
                sp <= sp - 5'd1;
                pc <= stk[sp[3:0] - 4'd1];
              end
            end else st <= c8_pkg::ST_UNKNOWN;
          end
          4'h1: pc <= onnn;
          4'h2: begin
            if (sp >= 5'(c8_pkg::STACK_DEPTH)) st <= c8_pkg::ST_STACK_FAULT;
            else begin
              stk[sp[3:0]] <= nxt;
              sp <= sp + 5'd1;
              pc <= onnn;
            end
          end
          4'h3: pc <= (vx == onn) ? skp : nxt;
          4'h4: pc <= (vx != onn) ? skp : nxt;
          4'h5: if (on != 4'd0) st <= c8_pkg::ST_UNKNOWN;
                else pc <= (vx == vy) ? skp : nxt;
          4'h6: begin vreg[ox] <= onn; pc <= nxt; end
          4'h7: begin vreg[ox] <= vx + onn; pc <= nxt; end
          4'h8: begin
            unique case (on)
              4'h0: begin vreg[ox] <= vy; pc <= nxt; end
              4'h1: begin vreg[ox] <= vx | vy; pc <= nxt; end
              4'h2: begin vreg[ox] <= vx & vy; pc <= nxt; end
              4'h3: begin vreg[ox] <= vx ^ vy; pc <= nxt; end
              4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                // flag wins when X is F
                if (ox != 4'hF) vreg[ox] <= alu_r;
                vreg[15] <= {7'd0, alu_f};
                pc <= nxt;
              end
              default: st <= c8_pkg::ST_UNKNOWN;
            endcase
          end
          4'h9: if (on != 4'd0) st <= c8_pkg::ST_UNKNOWN;
                else pc <= (vx != vy) ? skp : nxt;
          4'hA: begin idx <= {4'd0, onnn}; pc <= nxt; end
          4'hB: pc <= onnn + {4'd0, vreg[0]};
          4'hC: begin vreg[ox] <= onn & itm.random_byte; pc <= nxt; end
          4'hD: st <= c8_pkg::ST_UNSUPPORTED;
          4'hE: begin
            if (onn == 8'h9E) pc <= key ? skp : nxt;
            else if (onn == 8'hA1) pc <= key ? nxt : skp;
            else st <= c8_pkg::ST_UNKNOWN;
          end
          default: begin
            priority case (onn)
              8'h07: begin vreg[ox] <= dly; pc <= nxt; end
              8'h0A: st <= c8_pkg::ST_UNSUPPORTED;
              8'h15: begin dly <= vx; pc <= nxt; end
              8'h18: begin snd <= vx; pc <= nxt; end
              8'h1E: begin
                vreg[15] <= {7'd0, isum[16:12] != 5'd0};
                idx <= isum[15:0];
                pc <= nxt;
              end
              8'h29: begin idx <= {8'd0, vx} * 16'd5; pc <= nxt; end
              default: st <= c8_pkg::ST_UNKNOWN;
            endcase
          end
        endcase
      end
    end
  end

  // BCD by repeated subtraction, one compare a cycle
  always_ff @(posedge clk) begin
    if (ctrl.bcd_init) begin
      bcd_val <= vx; bcd_h <= 4'd0; bcd_t <= 4'd0;
    end else if (ctrl.bcd_step) begin
      if (bcd_val >= 8'd100) begin
        bcd_val <= bcd_val - 8'd100; bcd_h <= bcd_h + 4'd1;
      end else if (bcd_val >= 8'd10) begin
        bcd_val <= bcd_val - 8'd10; bcd_t <= bcd_t + 4'd1;
      end
    end
  end

  always_comb begin
    result.program_counter = pc;
    result.executed_opcode = op;
    result.status          = st;
    result.index_value     = idx;
    result.delay_value     = dly;
    result.sound_value     = snd;
  end

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= 5'(c8_pkg::STACK_DEPTH)) else $error("stack level overflow");
  a_load_op: assert property (@(posedge clk) disable iff (rst)
    done && !itm.cmd |-> op == 16'd0 && st == c8_pkg::ST_OK)
    else $error("load item reported opcode");
  a_fault_pc: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec && op[15:12] == 4'hD |=> $stable(pc)) else $error("pc moved on DXYN");
`endif

endmodule

[sv/c8_control.sv]
// ---------------------------------------------------------------------------
// CHIP-8 controller
// Sequences memory load, opcode fetch, execution and multi-byte transfers.
// ---------------------------------------------------------------------------
module c8_control (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cmd,
  input  c8_pkg::stat_t stat,
  output logic          busy,
  output c8_pkg::ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FETCH_HI, S_FETCH_LO, S_OP_LO, S_DISPATCH,
    S_BCD_CALC, S_BCD_WR, S_STORE, S_LOAD_RD, S_LOAD_WB, S_EMIT
  } state_t;

  state_t     state;
  logic [3:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= 4'd0;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= cmd ? S_FETCH_HI : S_LOAD;
        S_LOAD: state <= S_EMIT;
        S_FETCH_HI: state <= S_FETCH_LO;
        S_FETCH_LO: state <= S_OP_LO;
        S_OP_LO: state <= S_DISPATCH;
        S_DISPATCH: begin
          cnt <= 4'd0;
          unique case (stat.kind)
            c8_pkg::K_BCD:   state <= S_BCD_CALC;
            c8_pkg::K_STORE: state <= S_STORE;
            c8_pkg::K_LOAD:  state <= S_LOAD_RD;
            default:         state <= S_EMIT;
          endcase
        end
        S_BCD_CALC: begin
          // at most ten subtract steps (one hundred and nine tens); run twelve
          if (cnt == 4'd11) begin
            cnt <= 4'd0;
            state <= S_BCD_WR;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_BCD_WR: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) state <= S_EMIT;
        end
        S_STORE: begin
          cnt <= cnt + 4'd1;
          if (cnt == stat.x) state <= S_EMIT;
        end
        S_LOAD_RD: state <= S_LOAD_WB;
        S_LOAD_WB: begin
          cnt <= cnt + 4'd1;
          state <= (cnt == stat.x) ? S_EMIT : S_LOAD_RD;
        end
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy = (state != S_IDLE);
    ctrl = '0;
    ctrl.cnt = cnt;
    ctrl.maddr_sel = c8_pkg::MA_PC;
    ctrl.mdata_sel = c8_pkg::MD_LOAD;
    ctrl.latch_item = (state == S_IDLE) && start;
    unique case (state)
      S_LOAD: begin ctrl.maddr_sel = c8_pkg::MA_LOAD; ctrl.mem_we = 1'b1; end
      S_FETCH_HI: ctrl.mem_re = 1'b1;
      // high byte is on the read port now; take it while the low byte is read
      S_FETCH_LO: begin
        ctrl.maddr_sel = c8_pkg::MA_PC1;
        ctrl.mem_re = 1'b1;
        ctrl.op_hi_we = 1'b1;
      end
      S_OP_LO: ctrl.op_lo_we = 1'b1;
      S_DISPATCH: begin
        ctrl.exec = (stat.kind == c8_pkg::K_SIMPLE);
        ctrl.bcd_init = 1'b1;
      end
      S_BCD_CALC: ctrl.bcd_step = 1'b1;
      S_BCD_WR: begin
        ctrl.maddr_sel = c8_pkg::MA_IDX;
        ctrl.mdata_sel = c8_pkg::MD_BCD;
        ctrl.mem_we = 1'b1;
        ctrl.finish = (cnt == 4'd2);
      end
      S_STORE: begin
        ctrl.maddr_sel = c8_pkg::MA_IDX;
        ctrl.mdata_sel = c8_pkg::MD_REG;
        ctrl.mem_we = 1'b1;
        ctrl.idx_bump = (cnt == stat.x);
      end
      S_LOAD_RD: begin ctrl.maddr_sel = c8_pkg::MA_IDX; ctrl.mem_re = 1'b1; end
      S_LOAD_WB: begin
        ctrl.reg_ld = 1'b1;
        ctrl.idx_bump = (cnt == stat.x);
      end
      S_EMIT: ctrl.emit = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> !ctrl.emit) else $error("double emit");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.latch_item |-> !busy) else $error("accepted while busy");
  a_we_re: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.mem_we && ctrl.mem_re)) else $error("memory read and write together");
`endif

endmodule
